// ----- rtl/rmq_pkg.sv -----
// Shared types and helpers for the rotation-matrix to quaternion converter.
// No dependencies.
package rmq_pkg;

  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned RAD_W    = 35;
  localparam int unsigned ROOT_W   = 33;
  localparam int unsigned NUM_W    = 34;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic [1:0] axis;
    logic       pos_tr;
  } sel_t;

endpackage

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to quaternion converter, fully pipelined.
// Pipeline at FRAC_BITS = 30: 1 input stage + 17 root stages
// + 32 divide stages + 1 output register; both depths follow FRAC_BITS.
// Throughput: one item per cycle; the whole pipe stalls while the output waits.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// Depends on rmq_pkg, rmq_sqrt_pipe, rmq_div_pipe.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata   // quat_w quat_x quat_y quat_z
);
  import rmq_pkg::*;

  localparam int TAG_W = 3 + 3 * NUM_W;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  elem_t m [9];
  for (genvar e = 0; e < 9; e++) begin : g_un
    assign m[e] = s_tdata[32*e +: 32];
  end

  // stage 1: trace, axis choice, numerators
  logic                    v1;
  sel_t                    sel1;
  logic signed [RAD_W-1:0] rad1;
  logic signed [NUM_W-1:0] n1 [3];

  always_comb begin
    logic signed [RAD_W-1:0] d0, d1, d2, tr;
    logic [1:0] ax;
    d0  = RAD_W'(m[0]);
    d1  = RAD_W'(m[4]);
    d2  = RAD_W'(m[8]);
    tr  = d0 + d1 + d2;
    ax = 2'd0;
    if (m[4] > m[0]) ax = 2'd1;
    if (m[8] > ((ax == 2'd1) ? m[4] : m[0])) ax = 2'd2;
    sel1.pos_tr = (tr > 0);
    sel1.axis   = ax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [RAD_W-1:0] d0, d1, d2, one, r;
    logic signed [NUM_W-1:0] e [9];
    if (en) begin
      for (int i = 0; i < 9; i++) e[i] = NUM_W'(m[i]);
      d0  = RAD_W'(m[0]);
      d1  = RAD_W'(m[4]);
      d2  = RAD_W'(m[8]);
      one = RAD_W'(1) <<< FRAC_BITS;
      if (sel1.pos_tr) begin
        r = d0 + d1 + d2 + one;
        n1[0] <= e[7] - e[5];
        n1[1] <= e[2] - e[6];
        n1[2] <= e[3] - e[1];
      end else begin
        case (sel1.axis)
          2'd0: begin
            r = d0 - d1 - d2 + one;
            n1[0] <= e[7] - e[5];
            n1[1] <= e[3] + e[1];
            n1[2] <= e[6] + e[2];
          end
          2'd1: begin
            r = d1 - d2 - d0 + one;
            n1[0] <= e[2] - e[6];
            n1[1] <= e[7] + e[5];
            n1[2] <= e[1] + e[3];
          end
          default: begin
            r = d2 - d0 - d1 + one;
            n1[0] <= e[3] - e[1];
            n1[1] <= e[2] + e[6];
            n1[2] <= e[5] + e[7];
          end
        endcase
      end
      rad1 <= (r > 0) ? r : '0;
    end
  end

  sel_t sel1r;
  always_ff @(posedge clk) begin
    if (en) begin
      sel1r.pos_tr <= sel1.pos_tr;
      sel1r.axis   <= sel1.axis;
    end
  end

  logic              v2;
  logic [ROOT_W-1:0] root2;
  logic [TAG_W-1:0]  tag2;

  rmq_sqrt_pipe #(.FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v1),
    .rad      (RAD_W'(rad1)),
    .in_tag   ({sel1r, n1[2], n1[1], n1[0]}),
    .out_valid(v2),
    .root     (root2),
    .out_tag  (tag2)
  );

  // divide stage
  elem_t qt [3];
  for (genvar d = 0; d < 3; d++) begin : g_div
    rmq_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (tag2[NUM_W*d +: NUM_W]),
      .den ({root2, 1'b0}),
      .quo (qt[d])
    );
  end

  localparam int DST = (NUM_W + FRAC_BITS + 1) / 2;
  logic              vd   [DST+1];
  sel_t              sd   [DST+1];
  logic [ROOT_W-1:0] hd   [DST+1];

  always_comb begin
    vd[0] = v2;
    sd[0] = tag2[TAG_W-1 -: 3];
    hd[0] = root2 >> 1;
  end

  for (genvar s = 0; s < DST; s++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[s+1] <= 1'b0;
      end else if (en) begin
        vd[s+1] <= vd[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd[s+1] <= sd[s];
        hd[s+1] <= hd[s];
      end
    end
  end

  elem_t hs;
  assign hs = (hd[DST] > ROOT_W'(32'h7FFF_FFFF)) ? elem_t'(32'h7FFF_FFFF)
                                                  : elem_t'(hd[DST]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd[DST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd[DST].pos_tr) begin
        m_tdata <= {qt[2], qt[1], qt[0], hs};
      end else begin
        case (sd[DST].axis)
          2'd0:    m_tdata <= {qt[2], qt[1], hs, qt[0]};
          2'd1:    m_tdata <= {qt[1], hs, qt[2], qt[0]};
          default: m_tdata <= {hs, qt[2], qt[1], qt[0]};
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready mismatch");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("valid after reset");
`endif

endmodule

// ----- rtl/rmq_sqrt_pipe.sv -----
// Pipelined restoring square root of a RAD_W-bit value scaled by 2^FRAC_BITS.
// Depends on rmq_pkg. Two result bits per stage, one register stage per pair; carries a tag.
module rmq_sqrt_pipe #(
  parameter int FRAC_BITS = 30,
  parameter int TAG_W     = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rmq_pkg::RAD_W-1:0]  rad,
  input  logic [TAG_W-1:0]           in_tag,
  output logic                       out_valid,
  output logic [rmq_pkg::ROOT_W-1:0] root,
  output logic [TAG_W-1:0]           out_tag
);
  import rmq_pkg::*;

  localparam int VW    = RAD_W + FRAC_BITS;
  localparam int RB    = (VW + 1) / 2;
  localparam int NST   = (RB + 1) / 2;
  localparam int RBP   = NST * 2;
  localparam int REM_W = RBP + 2;

  logic [NST:0]             vld;
  logic [2*RBP-1:0]         val [NST+1];
  logic [RBP-1:0]           res [NST+1];
  logic [REM_W-1:0]         rem [NST+1];
  logic [TAG_W-1:0]         tag [NST+1];

  always_comb begin
    vld[0] = in_valid;
    val[0] = (2*RBP)'({rad, FRAC_BITS'(0)});
    res[0] = '0;
    rem[0] = '0;
    tag[0] = in_tag;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [2*RBP-1:0] v_n;
    logic [RBP-1:0]   r_n;
    logic [REM_W-1:0] m_n;
    always_comb begin
      logic [REM_W-1:0] t;
      logic [REM_W-1:0] m;
      logic [RBP-1:0]   r;
      logic [2*RBP-1:0] v;
      m = rem[s];
      r = res[s];
      v = val[s];
      for (int b = 0; b < 2; b++) begin
        m = {m[REM_W-3:0], v[2*RBP-1 -: 2]};
        v = v << 2;
        t = {r[REM_W-3:0], 2'b01};
        if (m >= t) begin
          m = m - t;
          r = {r[RBP-2:0], 1'b1};
        end else begin
          r = {r[RBP-2:0], 1'b0};
        end
      end
      v_n = v;
      r_n = r;
      m_n = m;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        val[s+1] <= v_n;
        res[s+1] <= r_n;
        rem[s+1] <= m_n;
        tag[s+1] <= tag[s];
      end
    end
  end

  assign out_valid = vld[NST];
  assign root      = ROOT_W'(res[NST]);
  assign out_tag   = tag[NST];

endmodule

// ----- rtl/rmq_div_pipe.sv -----
// Pipelined signed restoring divider: (num * 2^FRAC_BITS) / den, truncating, clamped to 2^32.
// Depends on rmq_pkg. Two quotient bits per register stage; the output saturates to the signed 32-bit range.
module rmq_div_pipe #(
  parameter int FRAC_BITS = 30
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [rmq_pkg::NUM_W-1:0] num,
  input  logic [rmq_pkg::ROOT_W:0]       den,
  output logic signed [rmq_pkg::ELEM_W-1:0] quo
);
  import rmq_pkg::*;

  localparam int DW  = ROOT_W + 1;
  localparam int NW  = NUM_W + FRAC_BITS;
  localparam int NST = (NW + 1) / 2;
  localparam int QW  = NST * 2;
  localparam int RW  = DW + 2;

  logic [QW-1:0] dvd [NST+1];
  logic [RW-1:0] rem [NST+1];
  logic [DW-1:0] dv  [NST+1];
  logic          neg [NST+1];

  always_comb begin
    logic [NUM_W-1:0] mag;
    mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dvd[0] = QW'({mag, FRAC_BITS'(0)});
    rem[0] = '0;
    dv[0]  = den;
    neg[0] = num[NUM_W-1];
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [QW-1:0] q_n;
    logic [RW-1:0] r_n;
    always_comb begin
      logic [QW-1:0] q;
      logic [RW-1:0] r;
      q = dvd[s];
      r = rem[s];
      for (int b = 0; b < 2; b++) begin
        r = {r[RW-2:0], q[QW-1]};
        q = q << 1;
        if (r >= RW'(dv[s])) begin
          r    = r - RW'(dv[s]);
          q[0] = 1'b1;
        end
      end
      q_n = q;
      r_n = r;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dvd[s+1] <= q_n;
        rem[s+1] <= r_n;
        dv[s+1]  <= dv[s];
        neg[s+1] <= neg[s];
      end
    end
  end

  always_comb begin
    logic big;
    logic [ELEM_W:0] qm;
    big = (dvd[NST] > QW'(64'h1_0000_0000));
    qm  = big ? {1'b1, ELEM_W'(0)} : (ELEM_W+1)'(dvd[NST]);
    if (dv[NST] == '0) begin
      quo = '0;
    end else if (neg[NST]) begin
      quo = (qm >= (ELEM_W+1)'(33'h0_8000_0000)) ? elem_t'(32'h8000_0000)
                                                  : elem_t'(-qm);
    end else begin
      quo = (qm >= (ELEM_W+1)'(33'h0_8000_0000)) ? elem_t'(32'h7FFF_FFFF)
                                                  : elem_t'(qm);
    end
  end

endmodule

// ----- tb/rotation_matrix_to_quaternion_tb.sv -----
// Testbench for rotation_matrix_to_quaternion: drives matrices on the input stream,
// predicts each quaternion with a local fixed-point model and compares every field.
// Depends on the block only.
module rotation_matrix_to_quaternion_tb;

  localparam int FRAC = 30;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;

  quat_t expected_quats[$];
  int    mismatches;
  int    idle_cycles = 0;
  bit    timed_out = 1'b0;
  int    burst_left;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned fixed_root(longint v);
    if (v <= 0) return 0;
    return int_root(longint'(unsigned'(v)) << FRAC);
  endfunction

  function automatic longint fixed_quot(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    if (den == 0) return 0;
    mag = (num < 0) ? -num : num;
    q = (mag << FRAC) / den;
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    return sat32(num < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t matrix_to_quat(logic [287:0] d);
    longint m[3][3];
    longint q[4];
    longint tr;
    longint unsigned s;
    longint unsigned den;
    int i;
    int j;
    int k;
    quat_t r;
    for (int n = 0; n < 9; n++) m[n / 3][n % 3] = longint'($signed(d[n*32 +: 32]));
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      s = fixed_root(tr + (64'sd1 << FRAC));
      den = s << 1;
      q[0] = sat32(longint'(s >> 1));
      q[1] = fixed_quot(m[2][1] - m[1][2], den);
      q[2] = fixed_quot(m[0][2] - m[2][0], den);
      q[3] = fixed_quot(m[1][0] - m[0][1], den);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      s = fixed_root(m[i][i] - m[j][j] - m[k][k] + (64'sd1 << FRAC));
      den = s << 1;
      q[i + 1] = sat32(longint'(s >> 1));
      q[0] = fixed_quot(m[k][j] - m[j][k], den);
      q[j + 1] = fixed_quot(m[j][i] + m[i][j], den);
      q[k + 1] = fixed_quot(m[k][i] + m[i][k], den);
    end
    r.w = q[0][31:0];
    r.x = q[1][31:0];
    r.y = q[2][31:0];
    r.z = q[3][31:0];
    return r;
  endfunction

  // bursts of random length with random gaps
  task automatic send_matrix(logic [287:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_quats.push_back(matrix_to_quat(d));
  endtask

  function automatic logic [287:0] pack9(longint e[9]);
    logic [287:0] d;
    for (int n = 0; n < 9; n++) d[n*32 +: 32] = e[n][31:0];
    return d;
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return 32'(-$signed(32'($urandom_range(0, 32'h4000_0000))));
      3: return $urandom_range(0, 32'h4000_0000);
      4: return $urandom;
      default: return 32'($urandom_range(0, 8)) - 32'd4;
    endcase
  endfunction

  task automatic test_directed();
    longint one;
    longint e[9];
    one = 64'sd1 << FRAC;
    e = '{one, 0, 0, 0, one, 0, 0, 0, one};            send_matrix(pack9(e));
    e = '{one, 0, 0, 0, -one, 0, 0, 0, -one};          send_matrix(pack9(e));
    e = '{-one, 0, 0, 0, one, 0, 0, 0, -one};          send_matrix(pack9(e));
    e = '{-one, 0, 0, 0, -one, 0, 0, 0, one};          send_matrix(pack9(e));
    e = '{0, -one, 0, one, 0, 0, 0, 0, one};           send_matrix(pack9(e));
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send_matrix(pack9(e));
    // tied diagonals keep the lower index
    e = '{-one, 5, 7, 9, -one, 11, 13, 15, -one};      send_matrix(pack9(e));
    e = '{0, one, 0, one, 0, 0, 0, 0, -one};           send_matrix(pack9(e));
    // non-positive trace with full off-diagonals
    e = '{-one, one, one, one, 0, one, one, one, 0};   send_matrix(pack9(e));
    e = '{-2*one, one, one, one, -2*one, one, one, one, -2*one};
    send_matrix(pack9(e));
    // trace just positive, dominant last diagonal, full-scale patterns
    e = '{1, -one, one, one, 0, -one, -one, one, 0};   send_matrix(pack9(e));
    e = '{-one, 0, 0, 0, -one, 0, 0, 0, 2*one + 1};    send_matrix(pack9(e));
    for (int n = 0; n < 4; n++) begin
      for (int t = 0; t < 9; t++) e[t] = (n[0]) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
      if (n[1]) e[4] = 0;
      send_matrix(pack9(e));
    end
    e = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
          32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
    send_matrix(pack9(e));
  endtask

  // random elements: unit values, in-range values and full-width patterns
  task automatic test_random();
    logic [287:0] d;
    for (int n = 0; n < 1900; n++) begin
      for (int t = 0; t < 9; t++) d[t*32 +: 32] = rand_elem();
      send_matrix(d);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    mismatches = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    s_tvalid <= 1'b0;
    while (expected_quats.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && !timed_out) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // receiver stall pattern
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 3))
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ~m_tready;
      endcase
    end
  end

  always @(posedge clk) begin
    quat_t want;
    quat_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.w = m_tdata[31:0];
      got.x = m_tdata[63:32];
      got.y = m_tdata[95:64];
      got.z = m_tdata[127:96];
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion %h", m_tdata);
      end else begin
        want = expected_quats.pop_front();
        if (got.w !== want.w || got.x !== want.x || got.y !== want.y || got.z !== want.z)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("quaternion mismatch: exp w=%h x=%h y=%h z=%h got w=%h x=%h y=%h z=%h",
                     want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/rmq_pkg.sv
rtl/rmq_sqrt_pipe.sv
rtl/rmq_div_pipe.sv
rtl/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_tb.sv
